/* hdl/modular_exponent_and_divide_core_defines.svh */
// Assertion macros shared by the modular exponent and divide core.
// Included by the modules that carry assertions; no other dependencies.
`ifndef MODULAR_EXPONENT_AND_DIVIDE_CORE_DEFINES_SVH
`define MODULAR_EXPONENT_AND_DIVIDE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MEDC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in same cycle check");
`define MEDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed in next cycle check");
`else
`define MEDC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MEDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/medc_pkg.sv */
// Shared types, constants and the microcode table of the modular exponent core.
// No dependencies; imported by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package medc_pkg;

    localparam int unsigned DATA_W = 30;
    localparam int unsigned STEP_W = 5;

    localparam logic [DATA_W-1:0] MOD_P     = 30'd1000000007;
    localparam logic [DATA_W-1:0] EXP_INV   = 30'd1000000005;
    localparam logic [31:0]       MOD_P_X2  = 32'd2000000014;
    // floor(2^60 / p), the Barrett constant for 60-bit products.
    localparam logic [30:0]       BARRETT_M = 31'd1152921496;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_IDLE     = 5'd0;
    localparam t_step STEP_TEST     = 5'd1;
    localparam t_step STEP_BIT      = 5'd2;
    localparam t_step STEP_MUL      = 5'd3;
    localparam t_step STEP_MUL_QM   = 5'd4;
    localparam t_step STEP_MUL_QP   = 5'd5;
    localparam t_step STEP_MUL_FIX  = 5'd6;
    localparam t_step STEP_SQR      = 5'd7;
    localparam t_step STEP_SQR_QM   = 5'd8;
    localparam t_step STEP_SQR_QP   = 5'd9;
    localparam t_step STEP_SQR_FIX  = 5'd10;
    localparam t_step STEP_FIN      = 5'd11;
    localparam t_step STEP_DIV      = 5'd12;
    localparam t_step STEP_DIV_QM   = 5'd13;
    localparam t_step STEP_DIV_QP   = 5'd14;
    localparam t_step STEP_DIV_FIX  = 5'd15;
    localparam t_step STEP_DONE     = 5'd16;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_START = 3'd2,
        COND_EXP_ZERO = 3'd3,
        COND_EXP_EVEN = 3'd4,
        COND_NOT_DIV  = 3'd5
    } t_cond;

    typedef enum logic [2:0] {
        MOP_NONE   = 3'd0,
        MOP_ACC_SQ = 3'd1,
        MOP_SQ_SQ  = 3'd2,
        MOP_A_ACC  = 3'd3,
        MOP_QM     = 3'd4,
        MOP_QP     = 3'd5
    } t_mop;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_ACC  = 2'd1,
        DST_SQ   = 2'd2
    } t_dst;

    typedef struct packed {
        t_cond cond;
        t_step target;
        t_mop  mop;
        t_dst  dst;
        logic  shift;
        logic  load;
        logic  done;
    } t_uword;

    typedef struct packed {
        logic load;
        t_mop mop;
        t_dst dst;
        logic shift;
        logic done;
    } t_ctl;

    typedef struct packed {
        logic exp_zero;
        logic exp_even;
        logic is_div;
    } t_stat;

    // Each modular multiply takes four words: product, Barrett estimate,
    // quotient times p, then subtract and correct into the destination.
    function automatic t_uword ucode(input t_step addr);
        t_uword uw;
        uw = '{cond: COND_NEVER, target: STEP_IDLE, mop: MOP_NONE, dst: DST_NONE,
               shift: 1'b0, load: 1'b0, done: 1'b0};
        case (addr)
            STEP_IDLE: begin
                uw.cond   = COND_NO_START;
                uw.target = STEP_IDLE;
                uw.load   = 1'b1;
            end
            STEP_TEST: begin
                uw.cond   = COND_EXP_ZERO;
                uw.target = STEP_FIN;
            end
            STEP_BIT: begin
                uw.cond   = COND_EXP_EVEN;
                uw.target = STEP_SQR;
            end
            STEP_MUL:     uw.mop = MOP_ACC_SQ;
            STEP_MUL_QM:  uw.mop = MOP_QM;
            STEP_MUL_QP:  uw.mop = MOP_QP;
            STEP_MUL_FIX: uw.dst = DST_ACC;
            STEP_SQR:     uw.mop = MOP_SQ_SQ;
            STEP_SQR_QM:  uw.mop = MOP_QM;
            STEP_SQR_QP:  uw.mop = MOP_QP;
            STEP_SQR_FIX: begin
                uw.dst    = DST_SQ;
                uw.shift  = 1'b1;
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_TEST;
            end
            STEP_FIN: begin
                uw.cond   = COND_NOT_DIV;
                uw.target = STEP_DONE;
            end
            STEP_DIV:     uw.mop = MOP_A_ACC;
            STEP_DIV_QM:  uw.mop = MOP_QM;
            STEP_DIV_QP:  uw.mop = MOP_QP;
            STEP_DIV_FIX: uw.dst = DST_ACC;
            STEP_DONE: begin
                uw.done   = 1'b1;
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_IDLE;
            end
            default: begin
                uw.cond   = COND_ALWAYS;
                uw.target = STEP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

/* hdl/medc_seq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on medc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "modular_exponent_and_divide_core_defines.svh"

module medc_seq import medc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  busy
);

    t_step  r_pc;
    t_step  n_pc;
    t_uword uw;
    logic   take;

    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_START: take = !start;
            COND_EXP_ZERO: take = i_stat.exp_zero;
            COND_EXP_EVEN: take = i_stat.exp_even;
            COND_NOT_DIV:  take = !i_stat.is_div;
            default:       take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign busy        = (r_pc != STEP_IDLE);
    assign o_ctl.load  = uw.load & start;
    assign o_ctl.mop   = uw.mop;
    assign o_ctl.dst   = uw.dst;
    assign o_ctl.shift = uw.shift;
    assign o_ctl.done  = uw.done;

    `MEDC_ASSERT_NEXT(a_accept_enters_test, i_clk, i_rst_n, start && !busy, r_pc == STEP_TEST)
    `MEDC_ASSERT_NEXT(a_done_returns_idle, i_clk, i_rst_n, o_ctl.done, r_pc == STEP_IDLE)
    `MEDC_ASSERT_SAME(a_pc_in_program, i_clk, i_rst_n, 1'b1, r_pc <= STEP_DONE)

endmodule

/* hdl/medc_dp.sv */
// Datapath: operand registers, one shared 31x31 multiplier and Barrett correction.
// Depends on medc_pkg and the assertion macro header; driven by medc_seq.
`timescale 1ns / 1ps
`include "modular_exponent_and_divide_core_defines.svh"

module medc_dp import medc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic              i_req_type,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output t_stat             o_stat,
    output logic              o_result_valid,
    output logic [DATA_W-1:0] o_result_value
);

    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_sq;
    logic [DATA_W-1:0] r_exp;
    logic [DATA_W-1:0] r_a;
    logic              r_div;
    logic [61:0]       r_prod;
    logic [31:0]       r_x;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out;

    logic [30:0]       mul_a;
    logic [30:0]       mul_b;
    logic [31:0]       diff;
    logic [31:0]       fixed;
    logic [DATA_W-1:0] n_res;
    logic [DATA_W-1:0] load_src;
    logic [DATA_W-1:0] load_red;

    always_comb begin
        case (i_ctl.mop)
            MOP_ACC_SQ: begin
                mul_a = {1'b0, r_acc};
                mul_b = {1'b0, r_sq};
            end
            MOP_SQ_SQ: begin
                mul_a = {1'b0, r_sq};
                mul_b = {1'b0, r_sq};
            end
            MOP_A_ACC: begin
                mul_a = {1'b0, r_a};
                mul_b = {1'b0, r_acc};
            end
            MOP_QM: begin
                mul_a = r_prod[59:29];
                mul_b = BARRETT_M;
            end
            MOP_QP: begin
                mul_a = r_prod[61:31];
                mul_b = {1'b0, MOD_P};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The Barrett estimate leaves x - q*p below 3p, which fits in 32 bits.
    always_comb begin
        diff = r_x - r_prod[31:0];
        if (diff >= MOD_P_X2) begin
            fixed = diff - MOD_P_X2;
        end else if (diff >= {2'b00, MOD_P}) begin
            fixed = diff - {2'b00, MOD_P};
        end else begin
            fixed = diff;
        end
        n_res = fixed[DATA_W-1:0];
    end

    // A 30-bit operand is below 2p, so one subtraction reduces it.
    always_comb begin
        load_src = i_req_type ? i_operand_b : i_operand_a;
        load_red = (load_src >= MOD_P) ? load_src - MOD_P : load_src;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {31'd0, mul_a} * {31'd0, mul_b};
        if (i_ctl.mop == MOP_QM) begin
            r_x <= r_prod[31:0];
        end
        if (i_ctl.load) begin
            r_a   <= i_operand_a;
            r_acc <= DATA_W'(1);
            r_sq  <= load_red;
            r_exp <= i_req_type ? EXP_INV : i_operand_b;
            r_div <= i_req_type;
        end else begin
            if (i_ctl.dst == DST_ACC) begin
                r_acc <= n_res;
            end
            if (i_ctl.dst == DST_SQ) begin
                r_sq <= n_res;
            end
            if (i_ctl.shift) begin
                r_exp <= r_exp >> 1;
            end
        end
        if (i_ctl.done) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.done;
        end
    end

    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_even = !r_exp[0];
    assign o_stat.is_div   = r_div;
    assign o_result_valid  = r_out_valid;
    assign o_result_value  = r_out;

    `MEDC_ASSERT_NEXT(a_acc_reduced, i_clk, i_rst_n, i_ctl.dst == DST_ACC && !i_ctl.load, r_acc < MOD_P)
    `MEDC_ASSERT_NEXT(a_sq_reduced, i_clk, i_rst_n, i_ctl.load || i_ctl.dst == DST_SQ, r_sq < MOD_P)

endmodule

/* hdl/modular_exponent_and_divide_core.sv */
// Top level of the modular exponent and divide core (modulus 1000000007).
// Depends on medc_pkg, medc_seq and medc_dp.
`timescale 1ns / 1ps
//
// Usage: present a request word on i_req_type, i_operand_a and i_operand_b and
// raise start. The word is taken at a clock edge where start is high and busy
// is low. Request type 0 returns operand_a ^ operand_b mod p; type 1 returns
// operand_a / operand_b mod p through the Fermat inverse (a zero divisor
// gives 0). The result word appears on o_result_value for exactly one cycle
// with o_result_valid high; there is no backpressure and the receiver must
// take it then.
// Operation: a microcode sequencer drives one shared 31x31 multiplier. Every
// modular multiply runs through product, Barrett estimate, quotient times p,
// then subtract and correct. Each exponent bit takes a test step, a bit step
// and a squaring, plus a multiply when the bit is set; the loop ends once no
// exponent bits remain. A divide adds one multiply by operand_a after the
// inverse. busy stays high from the accepting edge until the result word is
// issued, so one request is worked at a time.
// Reset returns the sequencer to idle and drops the result strobe.

module modular_exponent_and_divide_core import medc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output logic              o_result_valid,
    output logic [DATA_W-1:0] o_result_value
);

    t_ctl  ctl;
    t_stat stat;

    medc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    medc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value)
    );

endmodule
